@@ hdl/lff_pkg.sv @@
// Shared types and constants for the LUT function fitting block.
`default_nettype none

package lff_pkg;

	// Fixed field widths
	localparam int PAT_W  = 7;
	localparam int CFG_W  = 3;
	localparam int WORD_W = 64;

	// Reset value of the LUT input count
	localparam logic [CFG_W-1:0] LUT_INPUTS_RST = 3'd3;

	// Largest input count whose function fits in one word
	localparam logic [CFG_W-1:0] ONE_WORD_MAX_N = 3'd6;

	// One finished set, handed from the fitting stage to the result buffer
	typedef struct packed {
		logic              possible;
		logic              two_words;
		logic [WORD_W-1:0] word1;
		logic [WORD_W-1:0] word0;
	} lff_set_t;

endpackage

`default_nettype wire

@@ hdl/lff_fit.sv @@
// Input stage, pattern store and conflict tracking for LUT function fitting.
`default_nettype none

module lff_fit
	import lff_pkg::*;
#(
	parameter int MaxIn = 7
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [CFG_W-1:0]  lut_inputs,
	input  wire logic              item_valid,
	output logic                   item_ready,
	input  wire logic [PAT_W-1:0]  pattern_bits,
	input  wire logic              target_bit,
	input  wire logic              care_bit,
	input  wire logic              final_position,
	input  wire logic              set_free,
	output logic                   set_load,
	output lff_set_t               set_data
);

	localparam int IdxW   = MaxIn;
	localparam int StoreW = 1 << MaxIn;
	localparam logic [CFG_W-1:0] MAX_N = CFG_W'(MaxIn);

	logic             valid_s1;
	logic [PAT_W-1:0] pattern_s1;
	logic             target_s1;
	logic             care_s1;
	logic             final_s1;

	logic [StoreW-1:0] known_q;
	logic [StoreW-1:0] value_q;
	logic              conflict_q;

	logic [CFG_W-1:0]    n_eff;
	logic [IdxW-1:0]     idx_mask;
	logic [IdxW-1:0]     idx;
	logic                hit_known;
	logic                fresh;
	logic [StoreW-1:0]   known_nxt;
	logic [StoreW-1:0]   value_nxt;
	logic                conflict_nxt;
	logic                adv;
	logic [2*WORD_W-1:0] func_bits;

	// Saturate the configured input count into range
	always_comb begin
		if (lut_inputs == '0) begin
			n_eff = CFG_W'(1);
		end else if (lut_inputs > MAX_N) begin
			n_eff = MAX_N;
		end else begin
			n_eff = lut_inputs;
		end
	end

	// Keep only the low n_eff pattern bits
	always_comb begin
		for (int i = 0; i < IdxW; i++) begin
			idx_mask[i] = (CFG_W'(i) < n_eff);
		end
	end

	assign idx = pattern_s1[IdxW-1:0] & idx_mask;

	// Fold the held request into the store
	always_comb begin
		hit_known    = known_q[idx];
		fresh        = care_s1 && !hit_known;
		known_nxt    = known_q;
		value_nxt    = value_q;
		known_nxt[idx] = known_q[idx] | care_s1;
		if (fresh) begin
			value_nxt[idx] = target_s1;
		end
		conflict_nxt = conflict_q | (care_s1 & hit_known & (value_q[idx] != target_s1));
	end

	// Advance unless a final request waits for buffer room
	assign adv        = valid_s1 && (!final_s1 || set_free);
	assign item_ready = !valid_s1 || adv;
	assign set_load   = valid_s1 && final_s1 && set_free;

	// Function bits; patterns beyond the store read as zero
	for (genvar i = 0; i < 2*WORD_W; i++) begin : g_func
		if (i < StoreW) begin : g_in
			assign func_bits[i] = known_nxt[i] & value_nxt[i];
		end else begin : g_out
			assign func_bits[i] = 1'b0;
		end
	end

	always_comb begin
		set_data.possible  = !conflict_nxt;
		set_data.two_words = (n_eff > ONE_WORD_MAX_N);
		set_data.word1     = func_bits[2*WORD_W-1:WORD_W];
		set_data.word0     = func_bits[WORD_W-1:0];
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			pattern_s1 <= pattern_bits;
			target_s1  <= target_bit;
			care_s1    <= care_bit;
			final_s1   <= final_position;
		end
	end

	// Store update; clear it once a set is handed on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			known_q    <= '0;
			conflict_q <= 1'b0;
		end else if (adv) begin
			if (final_s1) begin
				known_q    <= '0;
				conflict_q <= 1'b0;
			end else begin
				known_q    <= known_nxt;
				conflict_q <= conflict_nxt;
			end
		end
	end

	// Value bits count only where known, so no clear is needed
	always_ff @(posedge clk) begin
		if (adv) begin
			value_q <= value_nxt;
		end
	end

endmodule

`default_nettype wire

@@ hdl/lff_outbuf.sv @@
// Result buffer that holds the one or two function words of a set.
`default_nettype none

module lff_outbuf
	import lff_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               set_load,
	input  wire lff_set_t           set_data,
	output logic                    set_free,
	output logic                    result_valid,
	input  wire logic               result_ready,
	output logic                    possible,
	output logic [WORD_W-1:0]       function_word,
	output logic                    word_index,
	output logic                    last_word
);

	logic [1:0]        cnt_q;
	logic              head_q;
	logic              possible_q;
	logic [WORD_W-1:0] word0_q;
	logic [WORD_W-1:0] word1_q;
	logic              pop;

	assign result_valid  = (cnt_q != 2'd0);
	assign pop           = result_valid && result_ready;
	assign set_free      = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && result_ready);
	assign possible      = possible_q;
	assign word_index    = head_q;
	assign last_word     = (cnt_q == 2'd1);
	assign function_word = head_q ? word1_q : word0_q;

	// Count and head: load a set or drop the presented word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= 2'd0;
			head_q <= 1'b0;
		end else if (set_load) begin
			cnt_q  <= set_data.two_words ? 2'd2 : 2'd1;
			head_q <= 1'b0;
		end else if (pop) begin
			cnt_q  <= cnt_q - 2'd1;
			head_q <= 1'b1;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (set_load) begin
			possible_q <= set_data.possible;
			word0_q    <= set_data.word0;
			word1_q    <= set_data.word1;
		end
	end

endmodule

`default_nettype wire

@@ hdl/lut_function_fit.sv @@
// Top level of the LUT function fitting block.
//
//  Channel   Handshake                  Payload
//  item      item_valid / item_ready    pattern_bits, target_bit, care_bit, final_position
//  result    result_valid / result_ready possible, function_word, word_index, last_word
//  config    cfg_wen                    cfg_wdata (lut_inputs)
//
// One request per cycle unless a final request waits for buffer room; the first result
// word is presented once its final request has passed the input register into the buffer.
// A final request waits in the input register until the result buffer has room,
// and a set with seven inputs is delivered as two result words.
// Reset clears the store, the conflict flag and the buffer at once; lut_inputs resets to 3.
// A stall on the result side holds the buffer; requests keep flowing until a final one.
`default_nettype none

module lut_function_fit
	import lff_pkg::*;
#(
	parameter int MAX_LUT_INPUTS = 7
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wen,
	input  wire logic [CFG_W-1:0]  cfg_wdata,
	input  wire logic              item_valid,
	output logic                   item_ready,
	input  wire logic [PAT_W-1:0]  pattern_bits,
	input  wire logic              target_bit,
	input  wire logic              care_bit,
	input  wire logic              final_position,
	output logic                   result_valid,
	input  wire logic              result_ready,
	output logic                   possible,
	output logic [WORD_W-1:0]      function_word,
	output logic                   word_index,
	output logic                   last_word
);

	logic [CFG_W-1:0] lut_inputs_q;
	logic             set_free;
	logic             set_load;
	lff_set_t         set_data;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lut_inputs_q <= LUT_INPUTS_RST;
		end else if (cfg_wen) begin
			lut_inputs_q <= cfg_wdata;
		end
	end

	lff_fit #(
		.MaxIn (MAX_LUT_INPUTS)
	) u_fit (
		.clk            (clk),
		.arst_n         (arst_n),
		.lut_inputs     (lut_inputs_q),
		.item_valid     (item_valid),
		.item_ready     (item_ready),
		.pattern_bits   (pattern_bits),
		.target_bit     (target_bit),
		.care_bit       (care_bit),
		.final_position (final_position),
		.set_free       (set_free),
		.set_load       (set_load),
		.set_data       (set_data)
	);

	lff_outbuf u_outbuf (
		.clk           (clk),
		.arst_n        (arst_n),
		.set_load      (set_load),
		.set_data      (set_data),
		.set_free      (set_free),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.possible      (possible),
		.function_word (function_word),
		.word_index    (word_index),
		.last_word     (last_word)
	);

endmodule

`default_nettype wire

@@ hdl/lff_checker.sv @@
// Port-level checks for the LUT function fitting block, bound to the top level.
`default_nettype none

module lff_checker
	import lff_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              result_valid,
	input wire logic              result_ready,
	input wire logic              possible,
	input wire logic [WORD_W-1:0] function_word,
	input wire logic              word_index,
	input wire logic              last_word
);

	// A stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=>
			result_valid && $stable(function_word) && $stable(word_index)
			&& $stable(last_word) && $stable(possible))
		else $error("stalled result word changed");

	// The upper word always closes a set
	a_upper_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && word_index |-> last_word)
		else $error("upper word not marked last");

	// A word that is not last is the lower word
	a_first_lower: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last_word |-> !word_index)
		else $error("non-last word is not the lower word");

	// Taking the lower word of a two-word set brings the upper word next
	a_upper_follows: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_ready && !last_word |=>
			result_valid && word_index && last_word && $stable(possible))
		else $error("upper word did not follow");

endmodule

bind lut_function_fit lff_checker u_lff_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.result_valid  (result_valid),
	.result_ready  (result_ready),
	.possible      (possible),
	.function_word (function_word),
	.word_index    (word_index),
	.last_word     (last_word)
);

`default_nettype wire

@@ bench/tb_top.sv @@
// Self-checking bench for lut_function_fit: random truth-table sets checked against a predictor.

module tb_top;
	import lff_pkg::*;

	localparam int MAX_INPUTS = 7;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_REQUESTS = 160;

	// One function word as the block should deliver it
	typedef struct packed {
		logic              possible;
		logic [WORD_W-1:0] function_word;
		logic              word_index;
		logic              last_word;
	} fit_word_t;

	// Predict the fitted function words and check the delivered ones
	class lut_fit_model;
		bit              known[128];
		bit              value[128];
		bit              conflict;
		logic [CFG_W-1:0] lut_inputs;
		fit_word_t       fit_words[$];
		int unsigned     errors;

		function new();
			lut_inputs = LUT_INPUTS_RST;
			errors = 0;
			clear_store();
		endfunction

		function void clear_store();
			foreach (known[i]) begin
				known[i] = 1'b0;
				value[i] = 1'b0;
			end
			conflict = 1'b0;
		endfunction

		function void set_lut_inputs(logic [CFG_W-1:0] v);
			lut_inputs = v;
		endfunction

		// Zero counts as one input; saturate at the largest LUT
		function int unsigned input_count();
			int unsigned n;
			n = (lut_inputs == 0) ? 1 : int'(lut_inputs);
			if (n > MAX_INPUTS)
				n = MAX_INPUTS;
			return n;
		endfunction

		function int pending();
			return fit_words.size();
		endfunction

		// Absorb one request; on the final one queue the function words and clear
		function void note_request(logic [PAT_W-1:0] pat, logic tgt, logic care, logic fin);
			int unsigned n;
			int unsigned idx;
			int unsigned words;
			fit_word_t w;
			n = input_count();
			idx = int'(pat) & ((1 << n) - 1);
			if (care) begin
				if (!known[idx]) begin
					known[idx] = 1'b1;
					value[idx] = tgt;
				end else if (value[idx] != tgt) begin
					conflict = 1'b1;
				end
			end
			if (!fin)
				return;
			words = (n > 6) ? 2 : 1;
			for (int k = 0; k < words; k++) begin
				w.possible = !conflict;
				w.function_word = '0;
				for (int p = 0; p < WORD_W; p++)
					w.function_word[p] = known[64 * k + p] & value[64 * k + p];
				w.word_index = k[0];
				w.last_word = (k == words - 1);
				fit_words.push_back(w);
			end
			clear_store();
		endfunction

		function void report(string field, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
			$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
			errors++;
		endfunction

		// Compare a delivered word with the oldest prediction
		function void check_word(fit_word_t got);
			fit_word_t want;
			if (fit_words.size() == 0) begin
				$display("%0t: unexpected result word %h", $time, got);
				errors++;
				return;
			end
			want = fit_words.pop_front();
			if (got.possible !== want.possible)
				report("possible", want.possible, got.possible);
			if (got.function_word !== want.function_word)
				report("function_word", want.function_word, got.function_word);
			if (got.word_index !== want.word_index)
				report("word_index", want.word_index, got.word_index);
			if (got.last_word !== want.last_word)
				report("last_word", want.last_word, got.last_word);
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_wen;
	logic [CFG_W-1:0]  cfg_wdata;
	logic              item_valid;
	logic              item_ready;
	logic [PAT_W-1:0]  pattern_bits;
	logic              target_bit;
	logic              care_bit;
	logic              final_position;
	logic              result_valid;
	logic              result_ready;
	logic              possible;
	logic [WORD_W-1:0] function_word;
	logic              word_index;
	logic              last_word;

	lut_fit_model model = new();
	int               snd_idle;
	int               rcv_idle;
	logic [CFG_W-1:0] cur_inputs;
	int               cycle_count;

	lut_function_fit #(.MAX_LUT_INPUTS(MAX_INPUTS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_wdata(cfg_wdata),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.pattern_bits(pattern_bits),
		.target_bit(target_bit),
		.care_bit(care_bit),
		.final_position(final_position),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.possible(possible),
		.function_word(function_word),
		.word_index(word_index),
		.last_word(last_word)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Stall the result side at random
	always @(negedge clk) begin
		result_ready <= ($urandom_range(0, 99) >= rcv_idle);
	end

	// Sample both handshakes at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready)
				model.check_word({possible, function_word, word_index, last_word});
			if (item_valid && item_ready)
				model.note_request(pattern_bits, target_bit, care_bit, final_position);
		end
	end

	// Give up on a hung block
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	// Offer one request after a random gap and hold it until taken
	task automatic send_item(logic [PAT_W-1:0] pat, logic tgt, logic care, logic fin);
		while ($urandom_range(0, 99) < snd_idle) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		pattern_bits <= pat;
		target_bit <= tgt;
		care_bit <= care;
		final_position <= fin;
		do
			@(posedge clk);
		while (!item_ready);
		@(negedge clk);
	endtask

	// Hold off requests until every predicted word has arrived, then let the block settle
	task automatic wait_drained();
		item_valid <= 1'b0;
		while (model.pending() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_lut_inputs(logic [CFG_W-1:0] v);
		wait_drained();
		cfg_wen <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_wen <= 1'b0;
		model.set_lut_inputs(v);
		cur_inputs = v;
	endtask

	// Stream sets: mostly consistent functions, some with a few flipped
	// targets, some pure noise; some sets walk the whole table in order
	task automatic run_phase(int budget);
		int               sent;
		int               len;
		int               kind;
		int               flip_pct;
		int unsigned      n;
		int unsigned      mask;
		bit               walk;
		logic [127:0]     fn;
		logic [PAT_W-1:0] pat;
		logic             tgt;
		logic             care;
		sent = 0;
		n = (cur_inputs == 0) ? 1 : int'(cur_inputs);
		mask = (1 << n) - 1;
		while (sent < budget) begin
			fn = {$urandom, $urandom, $urandom, $urandom};
			kind = $urandom_range(0, 99);
			flip_pct = (kind < 50) ? 0 : (kind < 85) ? 4 : 50;
			walk = ($urandom_range(0, 3) == 0) && (n < 7 || $urandom_range(0, 3) == 0);
			len = walk ? (1 << n) : $urandom_range(1, 24);
			for (int i = 0; i < len; i++) begin
				if (walk)
					pat = (PAT_W'($urandom) & ~PAT_W'(mask)) | PAT_W'(i);
				else
					pat = PAT_W'($urandom_range(0, 127));
				care = ($urandom_range(0, 3) != 0);
				tgt = fn[int'(pat) & mask];
				if ($urandom_range(0, 99) < flip_pct)
					tgt = ~tgt;
				send_item(pat, tgt, care, i == len - 1);
			end
			sent += len;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_wdata = '0;
		item_valid = 1'b0;
		pattern_bits = '0;
		target_bit = 1'b0;
		care_bit = 1'b0;
		final_position = 1'b0;
		result_ready = 1'b0;
		cur_inputs = LUT_INPUTS_RST;
		snd_idle = 24;
		rcv_idle = 55;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset width of three: upper pattern bits dropped, conflict keeps first value
		send_item(7'h7F, 1'b1, 1'b1, 1'b0);
		send_item(7'h00, 1'b0, 1'b1, 1'b0);
		send_item(7'h07, 1'b0, 1'b1, 1'b0);
		send_item(7'h00, 1'b1, 1'b0, 1'b0);
		send_item(7'h78, 1'b1, 1'b1, 1'b1);
		// Repeat agreement and a don't-care: still possible
		send_item(7'h05, 1'b1, 1'b1, 1'b0);
		send_item(7'h02, 1'b1, 1'b0, 1'b0);
		send_item(7'h05, 1'b1, 1'b1, 1'b1);
		// Single-position set
		send_item(7'h2A, 1'b1, 1'b1, 1'b1);
		// Zero inputs acts as one
		write_lut_inputs(3'd0);
		send_item(7'h03, 1'b1, 1'b1, 1'b0);
		send_item(7'h00, 1'b1, 1'b1, 1'b0);
		send_item(7'h7E, 1'b0, 1'b0, 1'b1);
		// Seven inputs: both words, patterns at either end of each word
		write_lut_inputs(3'd7);
		send_item(7'h7F, 1'b1, 1'b1, 1'b0);
		send_item(7'h40, 1'b1, 1'b1, 1'b0);
		send_item(7'h3F, 1'b1, 1'b1, 1'b0);
		send_item(7'h00, 1'b1, 1'b1, 1'b0);
		send_item(7'h7F, 1'b0, 1'b1, 1'b0);
		send_item(7'h01, 1'b0, 1'b0, 1'b1);

		// Sender idles lightly, receiver heavily
		write_lut_inputs(3'd3);
		run_phase(PHASE_REQUESTS);
		write_lut_inputs(3'd6);
		run_phase(PHASE_REQUESTS);
		write_lut_inputs(3'd0);
		run_phase(PHASE_REQUESTS);

		// Swap the idling
		snd_idle = 55;
		rcv_idle = 24;
		write_lut_inputs(3'd1);
		run_phase(PHASE_REQUESTS);
		write_lut_inputs(3'd7);
		run_phase(PHASE_REQUESTS);
		write_lut_inputs(3'd2);
		run_phase(PHASE_REQUESTS);

		// Full rate on both sides
		snd_idle = 0;
		rcv_idle = 0;
		write_lut_inputs(3'd4);
		run_phase(PHASE_REQUESTS);
		write_lut_inputs(3'd5);
		run_phase(PHASE_REQUESTS);
		write_lut_inputs(3'd3);
		run_phase(PHASE_REQUESTS);
		write_lut_inputs(3'd7);
		run_phase(PHASE_REQUESTS);

		// Drain and catch any stray words
		wait_drained();
		repeat (20) @(posedge clk);
		if (model.errors == 0 && model.pending() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/lff_pkg.sv
hdl/lff_fit.sv
hdl/lff_outbuf.sv
hdl/lut_function_fit.sv
hdl/lff_checker.sv
bench/tb_top.sv
